@@ hw/rtl/mpmc_pkg.sv @@
// -----------------------------------------------------------------------------
// mpmc_pkg: shared types and constants for the multi-pattern match counter
// Opcode codes, sequencer states, store geometry.
// -----------------------------------------------------------------------------
package mpmc_pkg;

  localparam int unsigned MAX_NODES    = 65536;
  localparam int unsigned ALPHABET     = 128;
  localparam int unsigned MAX_PATTERNS = 1024;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned SYM_W  = $clog2(ALPHABET);
  localparam int unsigned PAT_W  = $clog2(MAX_PATTERNS);
  localparam int unsigned GOTO_W = NODE_W + SYM_W;
  localparam int unsigned USED_W = NODE_W + 1;
  localparam int unsigned NPAT_W = PAT_W + 1;   // msb set: no pattern
  localparam int unsigned HITS_W = 11;
  localparam int unsigned CNT_W  = 32;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [NPAT_W-1:0] NO_PAT   = {1'b1, {PAT_W{1'b0}}};

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_PCHAR = 3'd1,
    OP_BUILD = 3'd2,
    OP_TCHAR = 3'd3,
    OP_READ  = 3'd4
  } opcode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR_ROW,
    ST_PC_RD,
    ST_PC_WAIT,
    ST_PC_DEC,
    ST_PC_INIT,
    ST_BR_RD,
    ST_BR_WAIT,
    ST_BR_DEC,
    ST_BQ_POP,
    ST_BQ_WAIT,
    ST_BF_RD,
    ST_BF_WAIT,
    ST_BN_RD,
    ST_BN_WAIT,
    ST_BN_DEC,
    ST_CNT_CLR,
    ST_TC_RD,
    ST_TC_WAIT,
    ST_TC_NODE,
    ST_TC_NWAIT,
    ST_TC_CRD,
    ST_TC_CWAIT,
    ST_TC_CWR,
    ST_RD_CNT,
    ST_RD_WAIT,
    ST_OUT
  } state_t;

endpackage

@@ hw/rtl/mpmc_if.sv @@
// -----------------------------------------------------------------------------
// mpmc_in_if / mpmc_out_if: valid-ready channels of the match counter
// Source drives valid and payload, sink drives ready.
// -----------------------------------------------------------------------------
interface mpmc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [6:0] symbol;
  logic [9:0] pattern_index;
  logic       pattern_end;
  modport source (output valid, opcode, symbol, pattern_index, pattern_end, input ready);
  modport sink   (input valid, opcode, symbol, pattern_index, pattern_end, output ready);
endinterface

interface mpmc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_count;
  logic [10:0] hits_here;
  logic        status;
  modport source (output valid, match_count, hits_here, status, input ready);
  modport sink   (input valid, match_count, hits_here, status, output ready);
endinterface

@@ hw/rtl/mpmc_ram.sv @@
// -----------------------------------------------------------------------------
// mpmc_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// -----------------------------------------------------------------------------
module mpmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/multi_pattern_match_counter_unit.sv @@
// -----------------------------------------------------------------------------
// multi_pattern_match_counter_unit: Aho-Corasick multi-pattern counter
//
// Channel | Dir | Payload
// in_     | in  | opcode, symbol, pattern_index, pattern_end
// out_    | out | match_count, hits_here, status
//
// One transaction at a time; in_ready is high only in idle.
// Clear zeroes the root row. Pattern char looks up the child of the insert
// cursor; a new node gets its goto row written one entry a cycle.
// Build enqueues the root children, links each node breadth-first, all through
// the single goto RAM port, then clears the counts (only that once linked). Text
// char steps the scan cursor and walks the fail chain. Read fetches one count.
// Reset clears the count RAM and then the root row.
// A stalled result holds the sequencer in its output state.
// -----------------------------------------------------------------------------
module multi_pattern_match_counter_unit (
  input logic        clk,
  input logic        rst_n,
  mpmc_in_if.sink    in_ch,
  mpmc_out_if.source out_ch
);
  import mpmc_pkg::*;

  state_t state_r, state_nxt;

  // transaction fields
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic [PAT_W-1:0] pidx_r, pidx_nxt;
  logic             last_r, last_nxt;

  // architectural state
  logic [USED_W-1:0] used_r, used_nxt;
  logic [NODE_W-1:0] icur_r, icur_nxt;
  logic [NODE_W-1:0] scur_r, scur_nxt;
  logic              built_r, built_nxt;

  // working registers
  logic [NODE_W-1:0] node_r, node_nxt;     // current node / child
  logic [NODE_W-1:0] fnode_r, fnode_nxt;   // fail of current node
  logic [NODE_W-1:0] fval_r, fval_nxt;     // goto(fail, s)
  logic [SYM_W:0]    sidx_r, sidx_nxt;     // symbol sweep counter
  logic [USED_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PAT_W:0]    cidx_r, cidx_nxt;     // count clear sweep
  logic [NPAT_W-1:0] npat_r, npat_nxt;
  logic [HITS_W-1:0] hits_r, hits_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              stat_r, stat_nxt;

  // RAM ports
  logic              g_we, f_we, p_we, q_we, c_we;
  logic [GOTO_W-1:0] g_addr;
  logic [NODE_W-1:0] g_wd, g_rd, f_addr, f_wd, f_rd, p_addr, q_addr, q_wd, q_rd;
  logic [NPAT_W-1:0] p_wd, p_rd;
  logic [PAT_W-1:0]  c_addr;
  logic [CNT_W-1:0]  c_wd, c_rd;

  mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES*ALPHABET)) u_goto (
    .clk(clk), .we(g_we), .addr(g_addr), .wdata(g_wd), .rdata(g_rd));
  mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));
  mpmc_ram #(.WIDTH(NPAT_W), .DEPTH(MAX_NODES)) u_npat (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));
  mpmc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wd), .rdata(q_rd));
  mpmc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_PATTERNS)) u_cnt (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));

  logic [SYM_W-1:0] s_lo;
  assign s_lo = sidx_r[SYM_W-1:0];

  // state and data registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CNT_CLR;
      used_r  <= USED_W'(1);
      icur_r  <= '0;
      scur_r  <= '0;
      built_r <= 1'b0;
      cidx_r  <= '0;
      sidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      icur_r  <= icur_nxt;
      scur_r  <= scur_nxt;
      built_r <= built_nxt;
      cidx_r  <= cidx_nxt;
      sidx_r  <= sidx_nxt;
    end
    sym_r   <= sym_nxt;
    pidx_r  <= pidx_nxt;
    last_r  <= last_nxt;
    node_r  <= node_nxt;
    fnode_r <= fnode_nxt;
    fval_r  <= fval_nxt;
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    npat_r  <= npat_nxt;
    hits_r  <= hits_nxt;
    cnt_r   <= cnt_nxt;
    stat_r  <= stat_nxt;
  end

  // reset clear pass: root row is cleared after counts, then straight to idle
  logic rst_root_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rst_root_r <= 1'b1;
    else if (state_r == ST_CLR_ROW && sidx_r == (SYM_W+1)'(ALPHABET-1)) rst_root_r <= 1'b0;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    sym_nxt = sym_r;  pidx_nxt = pidx_r;
    last_nxt = last_r;
    used_nxt = used_r;  icur_nxt = icur_r;  scur_nxt = scur_r;
    built_nxt = built_r;
    node_nxt = node_r;  fnode_nxt = fnode_r;  fval_nxt = fval_r;
    sidx_nxt = sidx_r;  head_nxt = head_r;  tail_nxt = tail_r;
    cidx_nxt = cidx_r;  npat_nxt = npat_r;  hits_nxt = hits_r;
    cnt_nxt = cnt_r;  stat_nxt = stat_r;
    g_we = 1'b0;  g_addr = '0;  g_wd = '0;
    f_we = 1'b0;  f_addr = '0;  f_wd = '0;
    p_we = 1'b0;  p_addr = '0;  p_wd = '0;
    q_we = 1'b0;  q_addr = '0;  q_wd = '0;
    c_we = 1'b0;  c_addr = '0;  c_wd = '0;
    in_ch.ready = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          sym_nxt  = in_ch.symbol;
          pidx_nxt = in_ch.pattern_index;
          last_nxt = in_ch.pattern_end;
          cnt_nxt  = '0;  hits_nxt = '0;  stat_nxt = 1'b0;
          sidx_nxt = '0;
          case (in_ch.opcode)
            OP_CLEAR: state_nxt = ST_CLR_ROW;
            OP_PCHAR: state_nxt = built_r ? ST_OUT : ST_PC_RD;
            OP_BUILD: begin
              cidx_nxt  = '0;
              head_nxt  = '0;  tail_nxt = '0;
              state_nxt = built_r ? ST_CNT_CLR : ST_BR_RD;
            end
            OP_TCHAR: state_nxt = built_r ? ST_TC_RD : ST_OUT;
            OP_READ:  state_nxt = ST_RD_CNT;
            default:  state_nxt = ST_OUT;
          endcase
        end
      end

      // zero the root row and root pattern, reset cursors
      ST_CLR_ROW: begin
        g_we = 1'b1;
        g_addr = {NODE_W'(0), s_lo};
        p_we = 1'b1;  p_wd = NO_PAT;
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == (SYM_W+1)'(ALPHABET-1)) begin
          used_nxt = USED_W'(1);  icur_nxt = '0;  scur_nxt = '0;
          built_nxt = 1'b0;
          state_nxt = rst_root_r ? ST_IDLE : ST_OUT;
        end
      end

      // pattern char: look up child of insert cursor
      ST_PC_RD: begin
        g_addr = {icur_r, sym_r};
        state_nxt = ST_PC_WAIT;
      end
      ST_PC_WAIT: begin
        g_addr = {icur_r, sym_r};
        state_nxt = ST_PC_DEC;
      end
      ST_PC_DEC: begin
        if (g_rd != '0) begin
          node_nxt = g_rd;
          if (last_r) begin
            p_we = 1'b1;  p_addr = g_rd;
            p_wd = {1'b0, pidx_r};
            icur_nxt = '0;
          end else begin
            icur_nxt = g_rd;
          end
          state_nxt = ST_OUT;
        end else if (used_r[NODE_W]) begin
          stat_nxt = 1'b1;
          if (last_r) icur_nxt = '0;
          state_nxt = ST_OUT;
        end else begin
          node_nxt = used_r[NODE_W-1:0];
          g_we = 1'b1;  g_addr = {icur_r, sym_r};  g_wd = used_r[NODE_W-1:0];
          p_we = 1'b1;  p_addr = used_r[NODE_W-1:0];
          p_wd = last_r ? {1'b0, pidx_r} : NO_PAT;
          icur_nxt = last_r ? '0 : used_r[NODE_W-1:0];
          used_nxt = used_r + 1'b1;
          sidx_nxt = '0;
          state_nxt = ST_PC_INIT;
        end
      end
      // zero the new node's goto row
      ST_PC_INIT: begin
        g_we = 1'b1;  g_addr = {node_r, s_lo};
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == (SYM_W+1)'(ALPHABET-1)) state_nxt = ST_OUT;
      end

      // build: enqueue root children
      ST_BR_RD: begin
        g_addr = {NODE_W'(0), s_lo};
        f_we = 1'b1;  f_addr = '0;  f_wd = '0;
        state_nxt = ST_BR_WAIT;
      end
      ST_BR_WAIT: begin
        g_addr = {NODE_W'(0), s_lo};
        state_nxt = ST_BR_DEC;
      end
      ST_BR_DEC: begin
        if (g_rd != '0) begin
          f_we = 1'b1;  f_addr = g_rd;  f_wd = '0;
          q_we = 1'b1;  q_addr = tail_r[NODE_W-1:0];  q_wd = g_rd;
          tail_nxt = tail_r + 1'b1;
        end
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == (SYM_W+1)'(ALPHABET-1)) state_nxt = ST_BQ_POP;
        else state_nxt = ST_BR_RD;
      end
      // pop next node, fetch its fail link
      ST_BQ_POP: begin
        if (head_r == tail_r) begin
          built_nxt = 1'b1;  cidx_nxt = '0;
          state_nxt = ST_CNT_CLR;
        end else begin
          q_addr = head_r[NODE_W-1:0];
          head_nxt = head_r + 1'b1;
          state_nxt = ST_BQ_WAIT;
        end
      end
      ST_BQ_WAIT: begin
        f_addr = q_rd;
        node_nxt = q_rd;
        sidx_nxt = '0;
        state_nxt = ST_BF_RD;
      end
      ST_BF_RD: begin
        fnode_nxt = f_rd;
        g_addr = {f_rd, s_lo};
        state_nxt = ST_BF_WAIT;
      end
      ST_BF_WAIT: begin
        g_addr = {fnode_r, s_lo};
        state_nxt = ST_BN_RD;
      end
      ST_BN_RD: begin
        fval_nxt = g_rd;
        g_addr = {node_r, s_lo};
        state_nxt = ST_BN_WAIT;
      end
      ST_BN_WAIT: begin
        g_addr = {node_r, s_lo};
        state_nxt = ST_BN_DEC;
      end
      ST_BN_DEC: begin
        if (g_rd == '0) begin
          g_we = 1'b1;  g_addr = {node_r, s_lo};  g_wd = fval_r;
        end else begin
          f_we = 1'b1;  f_addr = g_rd;  f_wd = fval_r;
          if (!tail_r[NODE_W]) begin
            q_we = 1'b1;  q_addr = tail_r[NODE_W-1:0];  q_wd = g_rd;
            tail_nxt = tail_r + 1'b1;
          end
        end
        sidx_nxt = sidx_r + 1'b1;
        if (sidx_r == (SYM_W+1)'(ALPHABET-1)) state_nxt = ST_BQ_POP;
        else state_nxt = ST_BF_WAIT;
      end

      // zero all pattern counts
      ST_CNT_CLR: begin
        c_we = 1'b1;  c_addr = cidx_r[PAT_W-1:0];  c_wd = '0;
        cidx_nxt = cidx_r + 1'b1;
        if (cidx_r == (PAT_W+1)'(MAX_PATTERNS-1)) begin
          scur_nxt = '0;
          if (rst_root_r) begin
            sidx_nxt = '0;
            state_nxt = ST_CLR_ROW;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end

      // text char: step, then walk fail chain
      ST_TC_RD: begin
        g_addr = {scur_r, sym_r};
        state_nxt = ST_TC_WAIT;
      end
      ST_TC_WAIT: begin
        scur_nxt = g_rd;
        node_nxt = g_rd;
        state_nxt = (g_rd == '0) ? ST_OUT : ST_TC_NODE;
      end
      ST_TC_NODE: begin
        p_addr = node_r;  f_addr = node_r;
        state_nxt = ST_TC_NWAIT;
      end
      ST_TC_NWAIT: begin
        npat_nxt = p_rd;
        fnode_nxt = f_rd;
        state_nxt = p_rd[PAT_W] ? ST_TC_CWR : ST_TC_CRD;
      end
      ST_TC_CRD: begin
        c_addr = npat_r[PAT_W-1:0];
        state_nxt = ST_TC_CWAIT;
      end
      ST_TC_CWAIT: begin
        c_we = 1'b1;  c_addr = npat_r[PAT_W-1:0];
        c_wd = (c_rd == CNT_MAX) ? c_rd : c_rd + 1'b1;
        if (hits_r != HITS_MAX) hits_nxt = hits_r + 1'b1;
        state_nxt = ST_TC_CWR;
      end
      ST_TC_CWR: begin
        node_nxt = fnode_r;
        state_nxt = (fnode_r == '0) ? ST_OUT : ST_TC_NODE;
      end

      // count read
      ST_RD_CNT: begin
        c_addr = pidx_r;
        state_nxt = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        cnt_nxt = c_rd;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid       = (state_r == ST_OUT);
  assign out_ch.match_count = cnt_r;
  assign out_ch.hits_here   = hits_r;
  assign out_ch.status      = stat_r;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench: regression for multi_pattern_match_counter_unit
// Builds small pattern sets, links them into an automaton, then scans text and
// reads counts. Each result is compared with an in-bench automaton model or with
// the result typed into a directed row. Runs under several sender and receiver idling mixes.
// -----------------------------------------------------------------------------
module testbench;
  import mpmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned ITEM_GOAL   = 800;

  typedef struct packed {
    logic [31:0] match_count;
    logic [10:0] hits_here;
    logic        status;
  } result_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] symbol;
    logic [9:0] pattern_index;
    logic       pattern_end;
    logic       typed;        // expected result given in the row
    result_t    result;
  } row_t;

  logic clk;
  logic rst_n;
  mpmc_in_if  in_ch ();
  mpmc_out_if out_ch ();

  multi_pattern_match_counter_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // automaton model state
  int unsigned goto_next[int unsigned];
  int unsigned fail_to[int unsigned];
  int unsigned node_pat[int unsigned];
  logic [31:0] pat_count[MAX_PATTERNS];
  int unsigned node_total;
  int unsigned insert_at;
  int unsigned scan_at;
  bit          linked;

  result_t     pending_results[$];
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned sent_count;
  int unsigned hit_results = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic int unsigned next_of(int unsigned node, int unsigned sym);
    int unsigned key;
    key = node * ALPHABET + sym;
    return goto_next.exists(key) ? goto_next[key] : 0;
  endfunction

  function automatic void fresh_node(int unsigned node);
    for (int unsigned s = 0; s < ALPHABET; s++) goto_next[node * ALPHABET + s] = 0;
    node_pat[node] = NO_PAT;
  endfunction

  function automatic void clear_automaton();
    fresh_node(0);
    node_total = 1;
    insert_at  = 0;
    scan_at    = 0;
    linked     = 0;
  endfunction

  // breadth-first fail links and goto completion
  function automatic void link_automaton();
    int unsigned bfs[$];
    int unsigned now, child, fnode;
    fail_to[0] = 0;
    for (int unsigned s = 0; s < ALPHABET; s++) begin
      child = next_of(0, s);
      if (child != 0) begin
        fail_to[child] = 0;
        bfs.push_back(child);
      end
    end
    while (bfs.size() != 0) begin
      now   = bfs.pop_front();
      fnode = fail_to[now];
      for (int unsigned s = 0; s < ALPHABET; s++) begin
        child = next_of(now, s);
        if (child == 0) begin
          goto_next[now * ALPHABET + s] = next_of(fnode, s);
        end else begin
          fail_to[child] = next_of(fnode, s);
          bfs.push_back(child);
        end
      end
    end
    linked = 1;
  endfunction

  function automatic result_t automaton_step(logic [2:0] op, logic [6:0] sym,
                                             logic [9:0] pidx, logic last);
    result_t     res;
    int unsigned child, now, hits;
    res = '0;
    case (op)
      OP_CLEAR: clear_automaton();
      OP_PCHAR: begin
        if (!linked) begin
          child = next_of(insert_at, sym);
          if (child == 0) begin
            if (node_total >= MAX_NODES) begin
              res.status = 1'b1;
              if (last) insert_at = 0;
              return res;
            end
            child = node_total;
            fresh_node(child);
            goto_next[insert_at * ALPHABET + sym] = child;
            node_total++;
          end
          if (last) begin
            node_pat[child] = pidx;
            insert_at = 0;
          end else begin
            insert_at = child;
          end
        end
      end
      OP_BUILD: begin
        if (!linked) link_automaton();
        for (int i = 0; i < MAX_PATTERNS; i++) pat_count[i] = '0;
        scan_at = 0;
      end
      OP_TCHAR: begin
        if (linked) begin
          scan_at = next_of(scan_at, sym);
          now  = scan_at;
          hits = 0;
          while (now != 0) begin
            if (node_pat[now] < MAX_PATTERNS) begin
              if (pat_count[node_pat[now]] != CNT_MAX)
                pat_count[node_pat[now]] = pat_count[node_pat[now]] + 1;
              if (hits < HITS_MAX) hits++;
            end
            now = fail_to[now];
          end
          res.hits_here = 11'(hits);
        end
      end
      OP_READ: res.match_count = pat_count[pidx];
      default: ;
    endcase
    return res;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multi_pattern_match_counter_unit regression: fail");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: count %0d hits %0d status %0d", $time,
                 out_ch.match_count, out_ch.hits_here, out_ch.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_ch.hits_here != 0) hit_results++;
        if (out_ch.match_count !== want.match_count) begin
          $display("%0t: match_count expected %0d actual %0d", $time,
                   want.match_count, out_ch.match_count);
          error_count++;
        end
        if (out_ch.hits_here !== want.hits_here) begin
          $display("%0t: hits_here expected %0d actual %0d", $time,
                   want.hits_here, out_ch.hits_here);
          error_count++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  // one transaction on the input channel; typed result overrides the model
  task automatic send_op(logic [2:0] op, logic [6:0] sym, logic [9:0] pidx, logic last,
                         bit typed = 0, result_t typed_res = '0);
    result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.symbol        <= sym;
    in_ch.pattern_index <= pidx;
    in_ch.pattern_end   <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = automaton_step(op, sym, pidx, last);
    pending_results.push_back(typed ? typed_res : res);
    sent_count++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_symbol();
    return ($urandom_range(0, 99) < 80) ? 7'(8'h61 + $urandom_range(0, 2))
                                        : 7'($urandom_range(0, 127));
  endfunction

  // directed rows
  row_t directed_rows[$];

  function automatic void add_row(opcode_t op, int sym, int pidx, bit last,
                                  bit typed = 0, int cnt = 0, int hits = 0);
    row_t r;
    r.opcode = op; r.symbol = 7'(sym); r.pattern_index = 10'(pidx); r.pattern_end = last;
    r.typed = typed;
    r.result = '{match_count: 32'(cnt), hits_here: 11'(hits), status: 1'b0};
    directed_rows.push_back(r);
  endfunction

  initial begin
    int unsigned used_pats[$];
    int unsigned session, n_pat, len, n_text;
    logic [9:0]  pidx;
    row_t        r;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = '0;
    in_ch.symbol        = '0;
    in_ch.pattern_index = '0;
    in_ch.pattern_end   = 1'b0;

    sent_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < MAX_PATTERNS; i++) pat_count[i] = '0;
    clear_automaton();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // after reset: zero counts, text ignored, unknown opcodes inert
    add_row(OP_READ, 0, 0, 0, 1);
    add_row(OP_READ, 0, 1023, 0, 1);
    add_row(OP_TCHAR, 8'h78, 0, 0, 1);
    add_row(opcode_t'(3'd5), 127, 1023, 1, 1);
    add_row(opcode_t'(3'd6), 0, 0, 0, 1);
    add_row(opcode_t'(3'd7), 85, 682, 1, 1);
    add_row(OP_CLEAR, 0, 0, 0, 1);
    // he(1), she(2), extreme symbols, then he again as 4 (duplicate overrides)
    add_row(OP_PCHAR, 8'h68, 0, 0);
    add_row(OP_PCHAR, 8'h65, 1, 1);
    add_row(OP_PCHAR, 8'h73, 0, 0);
    add_row(OP_PCHAR, 8'h68, 0, 0);
    add_row(OP_PCHAR, 8'h65, 2, 1);
    add_row(OP_PCHAR, 127, 1023, 1);
    add_row(OP_PCHAR, 0, 3, 1);
    add_row(OP_PCHAR, 8'h68, 0, 0);
    add_row(OP_PCHAR, 8'h65, 4, 1);
    add_row(OP_BUILD, 0, 0, 0, 1);
    add_row(OP_PCHAR, 8'h7a, 5, 1, 1);   // ignored once linked
    add_row(OP_TCHAR, 8'h73, 0, 0);
    add_row(OP_TCHAR, 8'h68, 0, 0);
    add_row(OP_TCHAR, 8'h65, 0, 0);
    add_row(OP_TCHAR, 127, 0, 0, 1, 0, 1);
    add_row(OP_TCHAR, 0, 0, 0, 1, 0, 1);
    add_row(OP_READ, 0, 1, 0, 1);
    add_row(OP_READ, 0, 4, 0);
    add_row(OP_READ, 0, 2, 0);
    add_row(OP_READ, 0, 1023, 0, 1, 1);
    add_row(OP_BUILD, 0, 0, 0, 1);       // rebuild zeroes counts
    add_row(OP_READ, 0, 4, 0, 1);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_op(r.opcode, r.symbol, r.pattern_index, r.pattern_end, r.typed, r.result);
    end

    // random sessions: clear, insert, build, scan and read
    session = 0;
    while (sent_count < ITEM_GOAL) begin
      case (session % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      if (session % 3 == 0) drain_results();
      used_pats.delete();
      send_op(OP_CLEAR, 7'($urandom), 10'($urandom), 1'($urandom));
      if ($urandom_range(0, 9) == 0) send_op(OP_TCHAR, pick_symbol(), 10'($urandom), 0);
      n_pat = $urandom_range(1, 5);
      for (int p = 0; p < n_pat; p++) begin
        len  = $urandom_range(1, 4);
        pidx = ($urandom_range(0, 99) < 70) ? 10'($urandom_range(0, 7)) : 10'($urandom);
        used_pats.push_back(pidx);
        for (int c = 0; c < len; c++)
          send_op(OP_PCHAR, pick_symbol(), (c == len - 1) ? pidx : 10'($urandom),
                  c == len - 1);
        if ($urandom_range(0, 19) == 0)
          send_op(opcode_t'(3'($urandom_range(5, 7))), 7'($urandom), 10'($urandom), 1);
      end
      // an unfinished pattern left hanging before the build
      if ($urandom_range(0, 4) == 0) send_op(OP_PCHAR, pick_symbol(), 10'($urandom), 0);
      send_op(OP_BUILD, 7'($urandom), 10'($urandom), 1'($urandom));
      if ($urandom_range(0, 4) == 0) send_op(OP_PCHAR, pick_symbol(), 10'($urandom), 1);
      n_text = $urandom_range(20, 40);
      for (int t = 0; t < n_text; t++) begin
        if ($urandom_range(0, 99) < 20)
          send_op(OP_READ, 7'($urandom), ($urandom_range(0, 3) != 0)
                  ? 10'(used_pats[$urandom_range(0, used_pats.size() - 1)])
                  : 10'($urandom), 1'($urandom));
        else
          send_op(OP_TCHAR, pick_symbol(), 10'($urandom), 1'($urandom));
        if ($urandom_range(0, 99) == 0)
          send_op(OP_BUILD, 7'($urandom), 10'($urandom), 1'($urandom));
      end
      foreach (used_pats[i]) send_op(OP_READ, 7'($urandom), 10'(used_pats[i]), 1'($urandom));
      session++;
    end

    // wind down
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d transactions over %0d pattern sessions; %0d results checked,",
             sent_count, session, checked_count);
    $display("%0d of them with pattern hits, under four idle/stall mixes.", hit_results);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("multi_pattern_match_counter_unit regression: pass");
    end else begin
      $display("multi_pattern_match_counter_unit regression: fail");
    end
    $finish;
  end

endmodule
